FILE: rtl/core/smd_pkg.sv
`default_nettype none
package smd_pkg;

   localparam int DELAY_DEPTH  = 2048;
   localparam int ADDR_W       = $clog2(DELAY_DEPTH);
   localparam int PTR_W        = ADDR_W + 8;
   localparam int SINE_ENTRIES = 1024;
   localparam int SINE_W       = $clog2(SINE_ENTRIES);
   localparam int SAMPLE_BITS  = 24;
   localparam int OUT_BITS     = SAMPLE_BITS + 1;
   localparam int LFO_W        = 24;
   localparam int GAIN_W       = 17;
   localparam int PHASE_W      = 32;
   localparam int DLY_W        = 19;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_STEP = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIX        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPAN       = 3'd4;

   typedef logic [LFO_W-1:0] sine_table_type [SINE_ENTRIES];

   // 0.5 + 0.5*sin, odd taylor polynomial in q30
   function automatic sine_table_type build_sine();
      sine_table_type t;
      longint u, z, z2, p, s, lv;
      for (int i = 0; i < SINE_ENTRIES; i++) begin
         u = (longint'(i) <<< 32) / SINE_ENTRIES;
         if (u < (longint'(1) <<< 30))
            z = u;
         else if (u < (longint'(3) <<< 30))
            z = (longint'(1) <<< 31) - u;
         else
            z = u - (longint'(1) <<< 32);
         z2 = (z * z) / 1073741824;
         p = 172273;
         p = -5026993 + (p * z2) / 1073741824;
         p = 85569306 + (p * z2) / 1073741824;
         p = -693598343 + (p * z2) / 1073741824;
         p = 1686629713 + (p * z2) / 1073741824;
         s = (z * p) / 1073741824;
         lv = (longint'(1) <<< 23) + s / 128;
         if (lv < 0) lv = 0;
         if (lv > 16777215) lv = 16777215;
         t[i] = LFO_W'(lv);
      end
      return t;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine();

   typedef struct packed {
      logic              done;
      logic [PTR_W-1:0]  rp;
      logic [GAIN_W-1:0] gain;
      logic [GAIN_W-1:0] wg;
   } lfo_res_type;

   typedef struct packed {
      logic              start;
      logic [PTR_W-1:0]  rp;
      logic [ADDR_W-1:0] wi;
      logic [GAIN_W-1:0] gain;
      logic [GAIN_W-1:0] dry;
      logic [GAIN_W-1:0] wg;
   } lane_cmd_type;

   typedef struct packed {
      logic ready;
      logic done;
   } lane_stat_type;

endpackage
`default_nettype wire

FILE: rtl/core/smd_lfo.sv
`default_nettype none
module smd_lfo (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [smd_pkg::PHASE_W-1:0] phase_step,
   input  wire logic [smd_pkg::GAIN_W-1:0]  depth,
   input  wire logic [smd_pkg::GAIN_W-1:0]  mix,
   input  wire logic [smd_pkg::DLY_W-1:0]   base,
   input  wire logic [smd_pkg::DLY_W-1:0]   span,
   input  wire logic [smd_pkg::ADDR_W-1:0]  wi,
   output smd_pkg::lfo_res_type             res
);
   import smd_pkg::*;

   localparam logic [21:0] SMOOTH_A = 22'd2147484;
   localparam logic [19:0] RECIP35  = 20'd958699;
   localparam logic [19:0] RECIP5   = 20'd838861;
   localparam logic [20:0] DL_LO    = 21'(10 * 256);
   localparam logic [20:0] DL_HI    = 21'((DELAY_DEPTH - 10) * 256);

   typedef enum logic [3:0] {
      F_IDLE, F_TAB, F_SMUL, F_SADD, F_DC, F_PLO, F_PHI, F_DL, F_RP
   } state_type;

   state_type state_ff;
   logic [PHASE_W-1:0] phase_ff;
   logic [LFO_W-1:0] sm_ff, sine_ff;
   logic [33:0] dsq_ff;
   logic [16:0] dc_ff;
   logic signed [47:0] smp_ff;
   logic [40:0] p_ff;
   logic [38:0] plo_ff;
   logic [39:0] phi_ff;
   logic [38:0] gq_ff, wq_ff;
   logic [20:0] dl_ff;
   logic done_ff;
   logic [PTR_W-1:0] rp_ff;
   logic [GAIN_W-1:0] gain_ff, wg_ff;

   logic [18:0] gnum, wnum;
   logic [20:0] wsum;
   logic signed [LFO_W+1:0] sm_in;
   logic [60:0] prod;
   logic [20:0] dl_in;

   always_comb begin
      gnum  = 19'(20'(depth) * 20'd10 - 20'd196591);
      wsum  = 21'(mix) * 21'd19 + 21'd10;
      wnum  = wsum[20:2];
      sm_in = $signed({2'b00, sm_ff})
              + 26'((smp_ff + 48'sd2147483648) >>> 32);
      prod  = {1'b0, phi_ff, 20'b0} + 61'(plo_ff) + (61'd1 << 39);
      dl_in = 21'(base) + 21'(prod[60:40]);
      if (dl_in < DL_LO) dl_in = DL_LO;
      if (dl_in > DL_HI) dl_in = DL_HI;
   end

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         state_ff <= F_IDLE;
         phase_ff <= '0;
         sm_ff    <= 24'd8388608;
      end else begin
         case (state_ff)
            F_IDLE: begin
               if (start) begin
                  phase_ff <= phase_ff + phase_step;
                  state_ff <= F_TAB;
               end
            end
            F_TAB: begin
               sine_ff  <= SINE_TABLE[phase_ff[PHASE_W-1 -: SINE_W]];
               dsq_ff   <= 34'(depth) * 34'(depth);
               gq_ff    <= 39'(gnum) * 39'(RECIP35);
               wq_ff    <= 39'(wnum) * 39'(RECIP5);
               state_ff <= F_SMUL;
            end
            F_SMUL: begin
               smp_ff   <= 48'(($signed({1'b0, sine_ff}) - $signed({1'b0, sm_ff}))
                           * $signed({1'b0, SMOOTH_A}));
               dc_ff    <= 17'((dsq_ff + 34'd32768) >> 16);
               gain_ff  <= (depth >= 17'd19661) ? 17'(17'd65536 - 17'(gq_ff >> 25))
                                                : 17'd65536;
               wg_ff    <= 17'(wq_ff >> 22);
               state_ff <= F_SADD;
            end
            F_SADD: begin
               if (sm_in > 26'sd16777215)
                  sm_ff <= 24'hFFFFFF;
               else
                  sm_ff <= sm_in[LFO_W-1:0];
               state_ff <= F_DC;
            end
            F_DC: begin
               p_ff     <= 41'(dc_ff) * 41'(sm_ff);
               state_ff <= F_PLO;
            end
            F_PLO: begin
               plo_ff   <= 39'(span) * 39'(p_ff[19:0]);
               state_ff <= F_PHI;
            end
            F_PHI: begin
               phi_ff   <= 40'(span) * 40'(p_ff[40:20]);
               state_ff <= F_DL;
            end
            F_DL: begin
               dl_ff    <= dl_in;
               state_ff <= F_RP;
            end
            F_RP: begin
               rp_ff    <= {wi, 8'b0} - dl_ff[PTR_W-1:0];
               done_ff  <= 1'b1;
               state_ff <= F_IDLE;
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

   assign res.done = done_ff;
   assign res.rp   = rp_ff;
   assign res.gain = gain_ff;
   assign res.wg   = wg_ff;

endmodule
`default_nettype wire

FILE: rtl/core/smd_lane.sv
`default_nettype none
module smd_lane (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire smd_pkg::lane_cmd_type               cmd,
   input  wire logic signed [smd_pkg::SAMPLE_BITS-1:0] x,
   output smd_pkg::lane_stat_type                   stat,
   output logic signed [smd_pkg::OUT_BITS-1:0]      y
);
   import smd_pkg::*;

   localparam logic signed [35:0] THR     = 36'sd8304768;
   localparam logic signed [35:0] OUT_MAX = 36'sd16777215;
   localparam logic signed [35:0] OUT_MIN = -36'sd16777216;

   typedef enum logic [3:0] {
      L_CLEAR, L_IDLE, L_READ, L_H1, L_H2, L_H3, L_WET, L_GAIN,
      L_DRY, L_MIX, L_CLIP, L_SOFT, L_SAT
   } state_type;

   logic signed [SAMPLE_BITS-1:0] mem [DELAY_DEPTH];
   logic signed [SAMPLE_BITS-1:0] rd_q;
   logic signed [SAMPLE_BITS-1:0] ysh_ff [4];

   state_type state_ff;
   logic [ADDR_W:0] clr_ff;
   logic [2:0] k_ff;
   logic signed [55:0] acc_ff;
   logic signed [31:0] wet_ff;
   logic signed [51:0] mix_ff;
   logic signed [35:0] o_ff;
   logic signed [52:0] cl_ff;
   logic done_ff;
   logic signed [OUT_BITS-1:0] y_ff;

   logic we;
   logic [ADDR_W-1:0] wa, ra, i1;
   logic signed [SAMPLE_BITS-1:0] wd;
   logic signed [41:0] st;
   logic signed [27:0] c0, c1, c2, c3, y0, y1, y2, y3;
   logic signed [9:0] f;
   logic signed [35:0] o_rnd, o_diff, o_sum;

   always_comb begin
      i1 = cmd.rp[PTR_W-1:8];
      f  = $signed({2'b00, cmd.rp[7:0]});
      ra = i1 + ADDR_W'(k_ff[1:0]) - ADDR_W'(1);
      st = (x * $signed(18'd65470) + 42'sd32768) >>> 16;
      we = (state_ff == L_CLEAR) || (state_ff == L_READ && k_ff == 3'd0);
      wa = (state_ff == L_CLEAR) ? clr_ff[ADDR_W-1:0] : cmd.wi;
      wd = (state_ff == L_CLEAR) ? '0 : st[SAMPLE_BITS-1:0];
      y0 = 28'(ysh_ff[0]);
      y1 = 28'(ysh_ff[1]);
      y2 = 28'(ysh_ff[2]);
      y3 = 28'(ysh_ff[3]);
      c0 = 28'sd2 * y1;
      c1 = y2 - y0;
      c2 = 28'sd2 * y0 - 28'sd5 * y1 + 28'sd4 * y2 - y3;
      c3 = (y3 - y0) + 28'sd3 * (y1 - y2);
      o_rnd = 36'((mix_ff + 52'sd32768) >>> 16);
      if (o_ff > THR)
         o_diff = o_ff - THR;
      else if (o_ff < -THR)
         o_diff = o_ff + THR;
      else
         o_diff = '0;
      if (o_ff > THR)
         o_sum = THR + 36'((cl_ff + 53'sd32768) >>> 16);
      else if (o_ff < -THR)
         o_sum = -THR + 36'((cl_ff + 53'sd32768) >>> 16);
      else
         o_sum = o_ff;
   end

   // delay store, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (we)
         mem[wa] <= wd;
      rd_q <= mem[ra];
   end

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         state_ff <= L_CLEAR;
         clr_ff   <= '0;
      end else begin
         case (state_ff)
            L_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (ADDR_W+1)'(DELAY_DEPTH - 1))
                  state_ff <= L_IDLE;
            end
            L_IDLE: begin
               k_ff <= '0;
               if (cmd.start)
                  state_ff <= L_READ;
            end
            L_READ: begin
               k_ff <= k_ff + 1'b1;
               if (k_ff != 3'd0) begin
                  ysh_ff[0] <= ysh_ff[1];
                  ysh_ff[1] <= ysh_ff[2];
                  ysh_ff[2] <= ysh_ff[3];
                  ysh_ff[3] <= rd_q;
               end
               if (k_ff == 3'd4)
                  state_ff <= L_H1;
            end
            L_H1: begin
               acc_ff   <= 56'(c3 * f) + 56'(c2) * 56'sd256;
               state_ff <= L_H2;
            end
            L_H2: begin
               acc_ff   <= 56'(acc_ff * f) + 56'(c1) * 56'sd65536;
               state_ff <= L_H3;
            end
            L_H3: begin
               acc_ff   <= 56'(acc_ff * f) + 56'(c0) * 56'sd16777216;
               state_ff <= L_WET;
            end
            L_WET: begin
               wet_ff   <= 32'((acc_ff + 56'sd16777216) >>> 25);
               state_ff <= L_GAIN;
            end
            L_GAIN: begin
               wet_ff   <= 32'((52'(wet_ff) * $signed({1'b0, cmd.gain}) + 52'sd32768)
                           >>> 16);
               state_ff <= L_DRY;
            end
            L_DRY: begin
               mix_ff   <= 52'(x * $signed({1'b0, cmd.dry}));
               state_ff <= L_MIX;
            end
            L_MIX: begin
               mix_ff   <= mix_ff + 52'(wet_ff * $signed({1'b0, cmd.wg}));
               state_ff <= L_CLIP;
            end
            L_CLIP: begin
               o_ff     <= o_rnd;
               state_ff <= L_SOFT;
            end
            L_SOFT: begin
               cl_ff    <= 53'(o_diff * $signed(17'd19661));
               state_ff <= L_SAT;
            end
            L_SAT: begin
               if (o_sum > OUT_MAX)
                  y_ff <= OUT_MAX[OUT_BITS-1:0];
               else if (o_sum < OUT_MIN)
                  y_ff <= OUT_MIN[OUT_BITS-1:0];
               else
                  y_ff <= o_sum[OUT_BITS-1:0];
               done_ff  <= 1'b1;
               state_ff <= L_IDLE;
            end
            default: state_ff <= L_IDLE;
         endcase
      end
   end

   assign stat.ready = (state_ff == L_IDLE);
   assign stat.done  = done_ff;
   assign y          = y_ff;

endmodule
`default_nettype wire

FILE: rtl/core/stereo_chorus_modulated_delay.sv
`default_nettype none
// stereo chorus: each frame advances a sine lfo, smooths it, turns it into a
// fractional delay and reads both delay lines back through 4-point catmull-rom
// interpolation, then mixes wet and dry, soft-clips and saturates to q2.23.
// one frame is worked at a time: the lfo and delay unit runs first, then the
// channel lanes (start, four reads on the single read port of each delay
// store, then the interpolation and mix multiplies), then the result passes to
// the output register, and the next frame can be taken once it is there. a
// result still waiting on rsp_tready holds the next frame at its last step
// until it goes out. after reset both delay stores are cleared, one entry a
// cycle, so no frame is taken until the clearing pass ends; config writes are
// taken throughout.
module stereo_chorus_modulated_delay (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // left_in[23:0], right_in[47:24]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // left_out[24:0], right_out[49:25], zero pad
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   import smd_pkg::*;

   typedef enum logic [1:0] {T_IDLE, T_LFO, T_LANE, T_OUT} state_type;

   state_type state_ff;

   // config registers
   logic [PHASE_W-1:0] step_ff;
   logic [GAIN_W-1:0] depth_ff, mix_ff;
   logic [DLY_W-1:0] base_ff, span_ff;

   logic [ADDR_W-1:0] wi_ff;
   logic signed [SAMPLE_BITS-1:0] xl_ff, xr_ff;
   logic go_ff;
   logic rsp_valid_ff;
   logic signed [OUT_BITS-1:0] left_ff, right_ff;

   logic req_fire;
   logic [GAIN_W-1:0] d_sat, m_sat;
   lfo_res_type lres;
   lane_cmd_type cmd;
   lane_stat_type lstat, rstat;
   logic signed [OUT_BITS-1:0] ly, ry;

   // depth and mix above one hold at one
   assign d_sat = (depth_ff > 17'd65536) ? 17'd65536 : depth_ff;
   assign m_sat = (mix_ff > 17'd65536) ? 17'd65536 : mix_ff;

   assign req_tready = (state_ff == T_IDLE) && lstat.ready && rstat.ready;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 32'd71583;
         depth_ff <= 17'd26214;
         mix_ff   <= 17'd32768;
         base_ff  <= 19'd184320;
         span_ff  <= 19'd86016;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PHASE_STEP: step_ff  <= csr_wdata;
            CSR_DEPTH:      depth_ff <= csr_wdata[GAIN_W-1:0];
            CSR_MIX:        mix_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_BASE:       base_ff  <= csr_wdata[DLY_W-1:0];
            CSR_SPAN:       span_ff  <= csr_wdata[DLY_W-1:0];
            default: ;  // index past the list is dropped
         endcase
      end
   end

   // frame sequencer and output register
   always_ff @(posedge clock) begin
      go_ff <= 1'b0;
      if (reset) begin
         state_ff     <= T_IDLE;
         wi_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_tready)
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            T_IDLE: begin
               if (req_fire) begin
                  xl_ff    <= req_tdata[23:0];
                  xr_ff    <= req_tdata[47:24];
                  state_ff <= T_LFO;
               end
            end
            T_LFO: begin
               if (lres.done) begin
                  go_ff    <= 1'b1;
                  state_ff <= T_LANE;
               end
            end
            T_LANE: begin
               if (lstat.done)
                  state_ff <= T_OUT;
            end
            T_OUT: begin
               // wait for the previous result transaction to go out
               if (!rsp_valid_ff || rsp_tready) begin
                  left_ff      <= ly;
                  right_ff     <= ry;
                  rsp_valid_ff <= 1'b1;
                  wi_ff        <= wi_ff + 1'b1;
                  state_ff     <= T_IDLE;
               end
            end
            default: state_ff <= T_IDLE;
         endcase
      end
   end

   smd_lfo u_lfo (
      .clock      (clock),
      .reset      (reset),
      .start      (req_fire),
      .phase_step (step_ff),
      .depth      (d_sat),
      .mix        (m_sat),
      .base       (base_ff),
      .span       (span_ff),
      .wi         (wi_ff),
      .res        (lres)
   );

   assign cmd.start = go_ff;
   assign cmd.rp    = lres.rp;
   assign cmd.wi    = wi_ff;
   assign cmd.gain  = lres.gain;
   assign cmd.dry   = 17'(17'd65536 - m_sat);
   assign cmd.wg    = lres.wg;

   // one lane per channel, same read pointer and gains
   smd_lane u_left (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .x     (xl_ff),
      .stat  (lstat),
      .y     (ly)
   );

   smd_lane u_right (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .x     (xr_ff),
      .stat  (rstat),
      .y     (ry)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, right_ff, left_ff};

endmodule
`default_nettype wire

FILE: dv/stereo_chorus_modulated_delay_tb.sv
`default_nettype none
module stereo_chorus_modulated_delay_tb;
   import smd_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;    // left_in[23:0], right_in[47:24]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;         // left_out[24:0], right_out[49:25], zero pad
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   stereo_chorus_modulated_delay dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // expected frames, left in low half
   typedef struct packed {
      logic signed [24:0] right_out;
      logic signed [24:0] left_out;
   } frame_out_type;

   // predictor copy of the settings and state
   logic [31:0] step_reg;
   logic [16:0] depth_reg;
   logic [16:0] mix_reg;
   logic [18:0] base_reg;
   logic [18:0] span_reg;
   logic [31:0] phase_acc;
   logic [23:0] lfo_smooth;
   logic [10:0] wr_ptr;
   longint      line_l [DELAY_DEPTH];
   longint      line_r [DELAY_DEPTH];
   longint      sine_lut [SINE_ENTRIES];

   frame_out_type expected_frames[$];
   int errors = 0;
   bit stall_on = 1'b0;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   // round half up by 2^n, arithmetic shift gives floor
   function automatic longint round_shift(input longint v, input int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
   endfunction

   // taylor sine table, same recipe as build_sine in smd_pkg
   task automatic fill_sine_lut();
      longint u, z, z2, p, s, lv;
      for (int i = 0; i < SINE_ENTRIES; i++) begin
         u = (longint'(i) <<< 32) / SINE_ENTRIES;
         if (u < (longint'(1) <<< 30)) z = u;
         else if (u < (longint'(3) <<< 30)) z = (longint'(1) <<< 31) - u;
         else z = u - (longint'(1) <<< 32);
         z2 = (z * z) / 1073741824;
         p = 172273;
         p = -5026993 + (p * z2) / 1073741824;
         p = 85569306 + (p * z2) / 1073741824;
         p = -693598343 + (p * z2) / 1073741824;
         p = 1686629713 + (p * z2) / 1073741824;
         s = (z * p) / 1073741824;
         lv = (longint'(1) <<< 23) + s / 128;
         if (lv < 0) lv = 0;
         if (lv > 16777215) lv = 16777215;
         sine_lut[i] = lv;
      end
   endtask

   // one channel: store, catmull-rom read, gain, mix, soft clip, saturate
   function automatic longint chorus_lane(ref longint line [DELAY_DEPTH], input longint x,
                                          input longint rp, input longint gain,
                                          input longint dry, input longint wg);
      longint i1, i0, i2, i3, f, y0, y1, y2, y3, c0, c1, c2, c3, acc, wet, o, thr;
      thr = ((longint'(1) <<< 23) * 64881 + 32768) / 65536;
      line[wr_ptr] = round_shift(x * 65470, 16);
      i1 = rp >> 8;
      f = rp & 255;
      i0 = (i1 + DELAY_DEPTH - 1) % DELAY_DEPTH;
      i2 = (i1 + 1) % DELAY_DEPTH;
      i3 = (i1 + 2) % DELAY_DEPTH;
      y0 = line[i0]; y1 = line[i1]; y2 = line[i2]; y3 = line[i3];
      c0 = 2 * y1;
      c1 = y2 - y0;
      c2 = 2 * y0 - 5 * y1 + 4 * y2 - y3;
      c3 = (y3 - y0) + 3 * (y1 - y2);
      acc = ((c3 * f + c2 * 256) * f + c1 * 65536) * f + c0 * 16777216;
      wet = round_shift(acc, 25);
      wet = round_shift(wet * gain, 16);
      o = round_shift(x * dry + wet * wg, 16);
      if (o > thr) o = thr + round_shift((o - thr) * 19661, 16);
      else if (o < -thr) o = -thr + round_shift((o + thr) * 19661, 16);
      if (o > 16777215) o = 16777215;
      if (o < -16777216) o = -16777216;
      return o;
   endfunction

   // advance lfo one frame and predict the stereo output
   task automatic predict_chorus_frame(input logic [47:0] frame);
      longint d, m, lfo, dc, dl, rp, gain, wg, dry;
      logic [63:0] sm;
      frame_out_type res;
      d = (depth_reg > 65536) ? 65536 : depth_reg;
      m = (mix_reg > 65536) ? 65536 : mix_reg;
      phase_acc = phase_acc + step_reg;
      lfo = sine_lut[phase_acc[31:22]];
      sm = (64'(lfo_smooth) * (64'h1_0000_0000 - 64'd2147484)
            + 64'(lfo) * 64'd2147484 + 64'h8000_0000) >> 32;
      if (sm > 64'd16777215) sm = 64'd16777215;
      lfo_smooth = sm[23:0];
      dc = (d * d + 32768) >> 16;
      // span*dc*sm fits below 2^63
      dl = longint'(base_reg) + ((longint'(span_reg) * dc * longint'(sm)
                                  + (longint'(1) <<< 39)) >>> 40);
      if (dl < 2560) dl = 2560;
      if (dl > (DELAY_DEPTH - 10) * 256) dl = (DELAY_DEPTH - 10) * 256;
      rp = ((longint'(wr_ptr) <<< 8) + DELAY_DEPTH * 256 - dl) % (DELAY_DEPTH * 256);
      gain = 65536;
      if (d >= 19661) gain = 65536 - (2 * (5 * d - 98304) + 17) / 35;
      wg = (m * 19 + 10) / 20;
      dry = 65536 - m;
      res.left_out = 25'(chorus_lane(line_l, longint'($signed(frame[23:0])), rp, gain, dry, wg));
      res.right_out = 25'(chorus_lane(line_r, longint'($signed(frame[47:24])), rp, gain, dry, wg));
      expected_frames.insert(expected_frames.size(), res);
      wr_ptr = wr_ptr + 1'b1;
   endtask

   // sender bursts: random burst length, random gaps
   int burst_left = 0;
   task automatic send_frame(input logic [23:0] left, input logic [23:0] right);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {right, left};
      predict_chorus_frame({right, left});
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic end_burst();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // config only while idle: drain, then allow for the block's latency
   task automatic write_csr(input logic [2:0] idx, input logic [31:0] val);
      end_burst();
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_PHASE_STEP: step_reg = val;
         CSR_DEPTH:      depth_reg = val[16:0];
         CSR_MIX:        mix_reg = val[16:0];
         CSR_BASE:       base_reg = val[18:0];
         CSR_SPAN:       span_reg = val[18:0];
         default: ;
      endcase
   endtask

   function automatic logic [23:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'($urandom_range(0, 4095)) - 24'd2048;
         default: return 24'($urandom);
      endcase
   endfunction

   // sample extremes, full scale square to hit the soft clip and saturation
   task automatic test_directed();
      send_frame(24'h000000, 24'h000000);
      send_frame(24'h7FFFFF, 24'h800000);
      send_frame(24'h800000, 24'h7FFFFF);
      send_frame(24'hFFFFFF, 24'h000001);
      for (int i = 0; i < 14; i++)
         send_frame(i[0] ? 24'h7FFFFF : 24'h800000, i[0] ? 24'h800000 : 24'h7FFFFF);
      send_frame(24'h555555, 24'hAAAAAA);
      send_frame(24'hAAAAAA, 24'h555555);
   endtask

   // random content under one setting
   task automatic test_random(input int n);
      for (int i = 0; i < n; i++) send_frame(rand_sample(), rand_sample());
   endtask

   // register extremes: depth/mix above one, delay clamps, phase wrap, bad index
   task automatic test_settings();
      write_csr(CSR_DEPTH, 32'h1FFFF);
      write_csr(CSR_MIX, 32'h1FFFF);
      write_csr(CSR_PHASE_STEP, 32'hFFFF_FFFF);
      test_random(150);
      write_csr(CSR_BASE, 32'd0);
      write_csr(CSR_SPAN, 32'd0);
      write_csr(CSR_MIX, 32'd0);
      test_random(100);
      write_csr(CSR_BASE, 32'hFFF7_FFFF);
      write_csr(CSR_SPAN, 32'h7FFFF);
      write_csr(CSR_MIX, 32'd65536);
      write_csr(CSR_DEPTH, 32'd65536);
      write_csr(3'd5, 32'hDEAD_BEEF);
      write_csr(3'd7, 32'h1234_5678);
      test_random(150);
      write_csr(CSR_DEPTH, 32'd0);
      write_csr(CSR_PHASE_STEP, 32'd0);
      write_csr(CSR_BASE, 32'd2560);
      test_random(100);
      write_csr(CSR_DEPTH, 32'd19661);
      write_csr(CSR_PHASE_STEP, 32'h0400_0000);
      write_csr(CSR_BASE, 32'd1000);
      write_csr(CSR_SPAN, 32'd300000);
      write_csr(CSR_MIX, 32'd40000);
      test_random(200);
      for (int k = 0; k < 6; k++) begin
         write_csr(CSR_PHASE_STEP, $urandom);
         write_csr(CSR_DEPTH, $urandom_range(0, 131071));
         write_csr(CSR_MIX, $urandom_range(0, 131071));
         write_csr(CSR_BASE, $urandom_range(0, 524287));
         write_csr(CSR_SPAN, $urandom_range(0, 524287));
         test_random(180);
      end
   endtask

   // receiver: stretches of no stall alternate with random stall patterns
   always @(posedge clock) begin
      if ($urandom_range(0, 99) == 0) stall_on <= ~stall_on;
      rsp_tready <= stall_on ? ($urandom_range(0, 2) == 0) : 1'b1;
   end

   // compare each accepted transaction with the oldest expected frame
   always @(posedge clock) begin
      frame_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_frames.size() == 0) begin
            report_mismatch("unexpected transaction", longint'(rsp_tdata[49:0]), 0);
         end else begin
            want = expected_frames.pop_front();
            if (rsp_tdata[24:0] !== want.left_out)
               report_mismatch("left_out", $signed(rsp_tdata[24:0]), want.left_out);
            if (rsp_tdata[49:25] !== want.right_out)
               report_mismatch("right_out", $signed(rsp_tdata[49:25]), want.right_out);
         end
      end
   end

   initial begin
      step_reg = 32'd71583;
      depth_reg = 17'd26214;
      mix_reg = 17'd32768;
      base_reg = 19'd184320;
      span_reg = 19'd86016;
      phase_acc = '0;
      lfo_smooth = 24'd8388608;
      wr_ptr = '0;
      for (int i = 0; i < DELAY_DEPTH; i++) begin
         line_l[i] = 0;
         line_r[i] = 0;
      end
      fill_sine_lut();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(250);
      test_settings();
      end_burst();
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0 && expected_frames.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // generous guard: ~2000 frames with stalls and gaps, plus the clearing pass
   initial begin
      #6000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
`default_nettype wire

FILE: sim.f
rtl/core/smd_pkg.sv
rtl/core/smd_lfo.sv
rtl/core/smd_lane.sv
rtl/core/stereo_chorus_modulated_delay.sv
dv/stereo_chorus_modulated_delay_tb.sv
